// ----- design/cau_pkg.sv -----
// shared constants and operation codes of the complex arithmetic unit
package cau_pkg;

  localparam int DEF_DATA_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int PORT_W         = 32;
  localparam int MAX_FRAC_BITS  = 31;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_MUL   = 3'd1,
    OP_DIV   = 3'd2,
    OP_MAGSQ = 3'd3,
    OP_MAG   = 3'd4
  } op_e;

endpackage

// ----- design/cau_iter_stage.sv -----
// one registered step of the divider lanes and the square root lane
module cau_iter_stage #(
  parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH,
  parameter int SIDE_W     = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [SIDE_W-1:0]         side_i,
  input  logic [2*DATA_WIDTH-1:0]   den_i,
  input  logic [2*DATA_WIDTH:0]     rem_re_i,
  input  logic [DATA_WIDTH-1:0]     nlo_re_i,
  input  logic [DATA_WIDTH-1:0]     q_re_i,
  input  logic [2*DATA_WIDTH:0]     rem_im_i,
  input  logic [DATA_WIDTH-1:0]     nlo_im_i,
  input  logic [DATA_WIDTH-1:0]     q_im_i,
  input  logic [DATA_WIDTH+2:0]     sq_rem_i,
  input  logic [DATA_WIDTH-1:0]     sq_root_i,
  input  logic [2*DATA_WIDTH-1:0]   sq_x_i,
  output logic                      valid_o,
  output logic [SIDE_W-1:0]         side_o,
  output logic [2*DATA_WIDTH-1:0]   den_o,
  output logic [2*DATA_WIDTH:0]     rem_re_o,
  output logic [DATA_WIDTH-1:0]     nlo_re_o,
  output logic [DATA_WIDTH-1:0]     q_re_o,
  output logic [2*DATA_WIDTH:0]     rem_im_o,
  output logic [DATA_WIDTH-1:0]     nlo_im_o,
  output logic [DATA_WIDTH-1:0]     q_im_o,
  output logic [DATA_WIDTH+2:0]     sq_rem_o,
  output logic [DATA_WIDTH-1:0]     sq_root_o,
  output logic [2*DATA_WIDTH-1:0]   sq_x_o
);

  localparam int W   = DATA_WIDTH;
  localparam int RW  = 2 * W + 1;
  localparam int SQW = W + 3;

  // restoring step: shift in one numerator bit, subtract the divisor if it fits
  function automatic logic [RW:0] div_step(input logic [RW-1:0] rem,
                                           input logic          nbit,
                                           input logic [2*W-1:0] den);
    logic [RW-1:0] sh;
    logic [RW-1:0] dx;
    sh = {rem[RW-2:0], nbit};
    dx = RW'(den);
    if (sh >= dx) begin
      div_step = {sh - dx, 1'b1};
    end else begin
      div_step = {sh, 1'b0};
    end
  endfunction

  logic              valid_q;
  logic [SIDE_W-1:0] side_q;
  logic [2*W-1:0]    den_q;
  logic [RW-1:0]     rem_re_q, rem_re_d, rem_im_q, rem_im_d;
  logic [W-1:0]      nlo_re_q, nlo_im_q, q_re_q, q_im_q;
  logic              bit_re, bit_im;
  logic [SQW-1:0]    sq_rem_q, sq_rem_d, sq_sh, sq_trial;
  logic [W-1:0]      sq_root_q;
  logic              sq_bit;
  logic [2*W-1:0]    sq_x_q;

  always_comb begin
    {rem_re_d, bit_re} = div_step(rem_re_i, nlo_re_i[W-1], den_i);
    {rem_im_d, bit_im} = div_step(rem_im_i, nlo_im_i[W-1], den_i);
  end

  // digit by digit square root, two radicand bits a step
  always_comb begin
    sq_sh    = {sq_rem_i[SQW-3:0], sq_x_i[2*W-1:2*W-2]};
    sq_trial = SQW'({sq_root_i, 2'b01});
    sq_bit   = (sq_sh >= sq_trial);
    sq_rem_d = sq_bit ? (sq_sh - sq_trial) : sq_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q    <= side_i;
      den_q     <= den_i;
      rem_re_q  <= rem_re_d;
      rem_im_q  <= rem_im_d;
      q_re_q    <= {q_re_i[W-2:0], bit_re};
      q_im_q    <= {q_im_i[W-2:0], bit_im};
      nlo_re_q  <= {nlo_re_i[W-2:0], 1'b0};
      nlo_im_q  <= {nlo_im_i[W-2:0], 1'b0};
      sq_rem_q  <= sq_rem_d;
      sq_root_q <= {sq_root_i[W-2:0], sq_bit};
      sq_x_q    <= {sq_x_i[2*W-3:0], 2'b00};
    end
  end

  assign valid_o   = valid_q;
  assign side_o    = side_q;
  assign den_o     = den_q;
  assign rem_re_o  = rem_re_q;
  assign rem_im_o  = rem_im_q;
  assign nlo_re_o  = nlo_re_q;
  assign nlo_im_o  = nlo_im_q;
  assign q_re_o    = q_re_q;
  assign q_im_o    = q_im_q;
  assign sq_rem_o  = sq_rem_q;
  assign sq_root_o = sq_root_q;
  assign sq_x_o    = sq_x_q;

endmodule

// ----- design/complex_arithmetic_unit.sv -----
// top level of the pipelined fixed-point complex arithmetic unit
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  operands A, B and operation
//  m_axis    out  m_axis_tvalid / m_axis_tready  result and status flags
//
// one item per cycle sustained while the output takes results; the divider and
//   square root lanes get one quotient and root bit a stage (Q16.16 by default)
// stages: operand register, products, sums, abs and saturation, divide set-up,
//   one iteration stage per quotient bit, an output register with one skid entry
// a stalled output parks one item in the skid entry; the pipeline holds only
//   when that entry is taken, so nothing is lost or repeated
// reset clears every valid bit; data registers are left as they are
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = cau_pkg::DEF_FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_re, a_im, b_re, b_im (32 bits each, lowest first)
  input  logic [127:0] s_axis_tdata,
  // operation
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_re, res_im (32 bits each, lowest first)
  output logic [63:0]  m_axis_tdata,
  // div_zero, overflow (lowest first)
  output logic [1:0]   m_axis_tuser
);

  import cau_pkg::*;

  // effective widths: values never exceed the 32 bit ports
  localparam int W    = (DATA_WIDTH > PORT_W) ? PORT_W : DATA_WIDTH;
  localparam int F    = (FRAC_BITS > MAX_FRAC_BITS) ? MAX_FRAC_BITS : FRAC_BITS;
  localparam int PW   = 2 * W;         // product
  localparam int SUMW = 2 * W + 1;     // sum of two products
  localparam int NW   = 2 * W + F;     // divide numerator at fraction scale
  localparam int CMPW = ((NW - W) > PW) ? (NW - W) : PW;
  localparam int RW   = 2 * W + 1;     // divider remainder
  localparam int SQW  = W + 3;         // square root remainder

  localparam logic signed [SUMW-1:0] SMAX = {{(SUMW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SMIN = {{(SUMW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // what rides alongside the iteration lanes
  typedef struct packed {
    op_e          op;
    logic [W-1:0] pre_re;
    logic [W-1:0] pre_im;
    logic         pre_ovf;
    logic         dz;
    logic         neg_re;
    logic         neg_im;
    logic         qovf_re;
    logic         qovf_im;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  // clamp to the value range, flag in the top bit
  function automatic logic [W:0] sat_fn(input logic signed [SUMW-1:0] v);
    if (v > SMAX) begin
      sat_fn = {1'b1, VMAX};
    end else if (v < SMIN) begin
      sat_fn = {1'b1, VMIN};
    end else begin
      sat_fn = {1'b0, v[W-1:0]};
    end
  endfunction

  // signed, saturated quotient from magnitude, sign and early overflow
  function automatic logic [W:0] quo_fn(input logic [W-1:0] q,
                                        input logic         neg,
                                        input logic         qovf);
    if (qovf) begin
      quo_fn = {1'b1, neg ? VMIN : VMAX};
    end else if (neg && (q != '0)) begin
      if (q > VMIN) begin
        quo_fn = {1'b1, VMIN};
      end else begin
        quo_fn = {1'b0, W'(~q + W'(1))};
      end
    end else if (q[W-1]) begin
      quo_fn = {1'b1, VMAX};
    end else begin
      quo_fn = {1'b0, q};
    end
  endfunction

  logic en;

  // ---------------- stage 1: operand register
  logic                s1_valid_q;
  op_e                 s1_op_q;
  logic signed [W-1:0] s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= op_e'(s_axis_tuser);
      s1_ar_q <= s_axis_tdata[W-1:0];
      s1_ai_q <= s_axis_tdata[32+W-1:32];
      s1_br_q <= s_axis_tdata[64+W-1:64];
      s1_bi_q <= s_axis_tdata[96+W-1:96];
    end
  end

  // ---------------- stage 2: the six products and the plain sums
  logic                 s2_valid_q;
  op_e                  s2_op_q;
  logic signed [PW-1:0] s2_m1_q, s2_m2_q, s2_m3_q, s2_m4_q, s2_m5_q, s2_m6_q;
  logic signed [W:0]    s2_add_re_q, s2_add_im_q;
  logic signed [W-1:0]  x5, x6;
  logic                 mag_op;

  // the squaring pair serves |B|^2 for divide and |A|^2 for the magnitudes
  assign mag_op = (s1_op_q == OP_MAGSQ) || (s1_op_q == OP_MAG);
  assign x5     = mag_op ? s1_ar_q : s1_br_q;
  assign x6     = mag_op ? s1_ai_q : s1_bi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q     <= s1_op_q;
      s2_m1_q     <= PW'(s1_ar_q) * PW'(s1_br_q);
      s2_m2_q     <= PW'(s1_ai_q) * PW'(s1_bi_q);
      s2_m3_q     <= PW'(s1_ar_q) * PW'(s1_bi_q);
      s2_m4_q     <= PW'(s1_ai_q) * PW'(s1_br_q);
      s2_m5_q     <= PW'(x5) * PW'(x5);
      s2_m6_q     <= PW'(x6) * PW'(x6);
      s2_add_re_q <= (W+1)'(s1_ar_q) + (W+1)'(s1_br_q);
      s2_add_im_q <= (W+1)'(s1_ai_q) + (W+1)'(s1_bi_q);
    end
  end

  // ---------------- stage 3: sums of products
  logic                   s3_valid_q;
  op_e                    s3_op_q;
  logic signed [SUMW-1:0] s3_mre_q, s3_mim_q, s3_nre_q, s3_nim_q, s3_sq_q;
  logic signed [W:0]      s3_add_re_q, s3_add_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_op_q     <= s2_op_q;
      s3_mre_q    <= SUMW'(s2_m1_q) - SUMW'(s2_m2_q);
      s3_mim_q    <= SUMW'(s2_m3_q) + SUMW'(s2_m4_q);
      s3_nre_q    <= SUMW'(s2_m1_q) + SUMW'(s2_m2_q);
      s3_nim_q    <= SUMW'(s2_m4_q) - SUMW'(s2_m3_q);
      s3_sq_q     <= SUMW'(s2_m5_q) + SUMW'(s2_m6_q);
      s3_add_re_q <= s2_add_re_q;
      s3_add_im_q <= s2_add_im_q;
    end
  end

  // ---------------- stage 4: early results, numerator magnitudes
  logic            s4_valid_q;
  logic [W-1:0]    pre_re_d, pre_im_d;
  logic            pre_ovf_d;
  logic [W:0]      sat_a, sat_b;
  logic [SUMW-1:0] abs_re, abs_im;
  side_t           s4_side_q;
  logic [PW-1:0]   s4_nmag_re_q, s4_nmag_im_q, s4_den_q;

  always_comb begin
    sat_a     = '0;
    sat_b     = '0;
    case (s3_op_q)
      OP_ADD: begin
        sat_a = sat_fn(SUMW'(s3_add_re_q));
        sat_b = sat_fn(SUMW'(s3_add_im_q));
      end
      OP_MUL: begin
        sat_a = sat_fn(s3_mre_q >>> F);
        sat_b = sat_fn(s3_mim_q >>> F);
      end
      OP_MAGSQ: begin
        sat_a = sat_fn(s3_sq_q >>> F);
      end
      default: begin
        sat_a = '0;
        sat_b = '0;
      end
    endcase
    pre_re_d  = sat_a[W-1:0];
    pre_im_d  = sat_b[W-1:0];
    pre_ovf_d = sat_a[W] | sat_b[W];
    abs_re    = s3_nre_q[SUMW-1] ? SUMW'(-s3_nre_q) : s3_nre_q;
    abs_im    = s3_nim_q[SUMW-1] ? SUMW'(-s3_nim_q) : s3_nim_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_side_q.op      <= s3_op_q;
      s4_side_q.pre_re  <= pre_re_d;
      s4_side_q.pre_im  <= pre_im_d;
      s4_side_q.pre_ovf <= pre_ovf_d;
      s4_side_q.dz      <= (s3_sq_q == '0);
      s4_side_q.neg_re  <= s3_nre_q[SUMW-1];
      s4_side_q.neg_im  <= s3_nim_q[SUMW-1];
      s4_side_q.qovf_re <= 1'b0;
      s4_side_q.qovf_im <= 1'b0;
      s4_nmag_re_q      <= abs_re[PW-1:0];
      s4_nmag_im_q      <= abs_im[PW-1:0];
      s4_den_q          <= s3_sq_q[PW-1:0];
    end
  end

  // ---------------- stage 5: scale numerators, catch quotients past W bits
  logic [NW-1:0]   n_re, n_im;
  logic [CMPW-1:0] top_re, top_im;
  side_t           side5_d;

  always_comb begin
    n_re            = NW'(s4_nmag_re_q) << F;
    n_im            = NW'(s4_nmag_im_q) << F;
    top_re          = CMPW'(n_re >> W);
    top_im          = CMPW'(n_im >> W);
    side5_d         = s4_side_q;
    side5_d.qovf_re = (top_re >= CMPW'(s4_den_q));
    side5_d.qovf_im = (top_im >= CMPW'(s4_den_q));
  end

  // lane buses, index k feeds iteration stage k
  logic              it_valid  [W+1];
  logic [SIDE_W-1:0] it_side   [W+1];
  logic [PW-1:0]     it_den    [W+1];
  logic [RW-1:0]     it_rem_re [W+1];
  logic [W-1:0]      it_nlo_re [W+1];
  logic [W-1:0]      it_q_re   [W+1];
  logic [RW-1:0]     it_rem_im [W+1];
  logic [W-1:0]      it_nlo_im [W+1];
  logic [W-1:0]      it_q_im   [W+1];
  logic [SQW-1:0]    it_sq_rem [W+1];
  logic [W-1:0]      it_sq_rt  [W+1];
  logic [PW-1:0]     it_sq_x   [W+1];

  logic              s5_valid_q;
  side_t             s5_side_q;
  logic [PW-1:0]     s5_den_q;
  logic [RW-1:0]     s5_rem_re_q, s5_rem_im_q;
  logic [W-1:0]      s5_nlo_re_q, s5_nlo_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_side_q   <= side5_d;
      s5_den_q    <= s4_den_q;
      s5_rem_re_q <= RW'(top_re);
      s5_rem_im_q <= RW'(top_im);
      s5_nlo_re_q <= n_re[W-1:0];
      s5_nlo_im_q <= n_im[W-1:0];
    end
  end

  assign it_valid[0]  = s5_valid_q;
  assign it_side[0]   = s5_side_q;
  assign it_den[0]    = s5_den_q;
  assign it_rem_re[0] = s5_rem_re_q;
  assign it_nlo_re[0] = s5_nlo_re_q;
  assign it_q_re[0]   = '0;
  assign it_rem_im[0] = s5_rem_im_q;
  assign it_nlo_im[0] = s5_nlo_im_q;
  assign it_q_im[0]   = '0;
  assign it_sq_rem[0] = '0;
  assign it_sq_rt[0]  = '0;
  assign it_sq_x[0]   = s5_den_q;

  // ---------------- iteration stages: one quotient bit and one root bit each
  for (genvar k = 0; k < W; k++) begin : g_iter
    cau_iter_stage #(
      .DATA_WIDTH (W),
      .SIDE_W     (SIDE_W)
    ) u_iter (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (it_valid[k]),
      .side_i    (it_side[k]),
      .den_i     (it_den[k]),
      .rem_re_i  (it_rem_re[k]),
      .nlo_re_i  (it_nlo_re[k]),
      .q_re_i    (it_q_re[k]),
      .rem_im_i  (it_rem_im[k]),
      .nlo_im_i  (it_nlo_im[k]),
      .q_im_i    (it_q_im[k]),
      .sq_rem_i  (it_sq_rem[k]),
      .sq_root_i (it_sq_rt[k]),
      .sq_x_i    (it_sq_x[k]),
      .valid_o   (it_valid[k+1]),
      .side_o    (it_side[k+1]),
      .den_o     (it_den[k+1]),
      .rem_re_o  (it_rem_re[k+1]),
      .nlo_re_o  (it_nlo_re[k+1]),
      .q_re_o    (it_q_re[k+1]),
      .rem_im_o  (it_rem_im[k+1]),
      .nlo_im_o  (it_nlo_im[k+1]),
      .q_im_o    (it_q_im[k+1]),
      .sq_rem_o  (it_sq_rem[k+1]),
      .sq_root_o (it_sq_rt[k+1]),
      .sq_x_o    (it_sq_x[k+1])
    );
  end

  // ---------------- result select per operation
  side_t               fin_sd;
  logic [W:0]          fq_re, fq_im;
  logic signed [W-1:0] fin_re, fin_im;
  logic                fin_dz, fin_ovf;
  logic                push;

  assign fin_sd = side_t'(it_side[W]);
  assign push   = en && it_valid[W];

  always_comb begin
    fq_re   = quo_fn(it_q_re[W], fin_sd.neg_re, fin_sd.qovf_re);
    fq_im   = quo_fn(it_q_im[W], fin_sd.neg_im, fin_sd.qovf_im);
    fin_re  = '0;
    fin_im  = '0;
    fin_dz  = 1'b0;
    fin_ovf = 1'b0;
    case (fin_sd.op)
      OP_ADD, OP_MUL, OP_MAGSQ: begin
        fin_re  = fin_sd.pre_re;
        fin_im  = fin_sd.pre_im;
        fin_ovf = fin_sd.pre_ovf;
      end
      OP_DIV: begin
        if (fin_sd.dz) begin
          // zero divisor: zero result, no overflow
          fin_dz = 1'b1;
        end else begin
          fin_re  = fq_re[W-1:0];
          fin_im  = fq_im[W-1:0];
          fin_ovf = fq_re[W] | fq_im[W];
        end
      end
      OP_MAG: begin
        if (it_sq_rt[W][W-1]) begin
          fin_re  = VMAX;
          fin_ovf = 1'b1;
        end else begin
          fin_re = it_sq_rt[W];
        end
      end
      default: begin
        fin_re = '0;
      end
    endcase
  end

  // ---------------- output register and skid entry
  logic        out_valid_q, skid_valid_q;
  logic [63:0] out_data_q, skid_data_q, fin_data;
  logic [1:0]  out_user_q, skid_user_q, fin_user;
  logic        pop;

  assign fin_data = {PORT_W'(fin_im), PORT_W'(fin_re)};
  assign fin_user = {fin_ovf, fin_dz};
  assign pop      = out_valid_q && m_axis_tready;
  // the pipeline moves while the skid entry is free
  assign en       = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_data_q <= fin_data;
        skid_user_q <= fin_user;
      end else begin
        out_data_q <= fin_data;
        out_user_q <= fin_user;
      end
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  // the skid entry is only ever filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds an item with no result in the output register");

  // a parked item stays parked until the output moves
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !pop |=> skid_valid_q)
    else $error("skid entry dropped without a transfer");

  // a zero divisor gives a zero result without overflow
  a_div_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_user_q[0] |-> (out_data_q == '0) && !out_user_q[1])
    else $error("divide by zero result is not clean");

  // magnitude results carry no imaginary part
  a_mag_im_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && ((fin_sd.op == OP_MAG) || (fin_sd.op == OP_MAGSQ)) |-> (fin_im == '0))
    else $error("magnitude result with nonzero imaginary part");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// testbench for the complex arithmetic unit: self-checking stream test against a predictor
module tb;
  import cau_pkg::*;

  localparam int W = DEF_DATA_WIDTH;
  localparam int F = DEF_FRAC_BITS;
  localparam int LATENCY = W + 6;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        overflow;
    logic        div_zero;
    logic [31:0] res_im;
    logic [31:0] res_re;
  } result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  result_t results_due[$];
  int      failures;
  longint  cycle_count;
  int      stall_mode;

  complex_arithmetic_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // clamp an exact signed value to the value width
  function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic ovf);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (W - 1)) - 1;
    lo = -(128'sd1 <<< (W - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi[31:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[31:0];
    end
    return v[31:0];
  endfunction

  // floor division by the fraction scale
  function automatic logic signed [127:0] drop_frac(input logic signed [127:0] v);
    return v >>> F;
  endfunction

  // truncated quotient num * 2^F / den, magnitude capped at 2^40
  function automatic logic signed [127:0] scaled_quot(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
    logic [127:0] m;
    logic [127:0] q;
    m = (num < 0) ? -num : num;
    q = (m << F) / den;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic result_t complex_result(input logic [2:0] op, input logic [31:0] a_re,
                                             input logic [31:0] a_im, input logic [31:0] b_re,
                                             input logic [31:0] b_im);
    result_t r;
    logic signed [127:0] ar, ai, br, bi, den;
    logic ovf;
    ar = $signed(a_re);
    ai = $signed(a_im);
    br = $signed(b_re);
    bi = $signed(b_im);
    ovf = 1'b0;
    r = '0;
    case (op)
      OP_ADD: begin
        r.res_re = clamp(ar + br, ovf);
        r.res_im = clamp(ai + bi, ovf);
      end
      OP_MUL: begin
        r.res_re = clamp(drop_frac(ar * br - ai * bi), ovf);
        r.res_im = clamp(drop_frac(ar * bi + ai * br), ovf);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_zero = 1'b1;
        end else begin
          r.res_re = clamp(scaled_quot(ar * br + ai * bi, den), ovf);
          r.res_im = clamp(scaled_quot(ai * br - ar * bi, den), ovf);
        end
      end
      OP_MAGSQ: r.res_re = clamp(drop_frac(ar * ar + ai * ai), ovf);
      OP_MAG: begin
        den = ar * ar + ai * ai;
        r.res_re = clamp($signed({64'd0, floor_sqrt(den[63:0])}), ovf);
      end
      default: ;
    endcase
    r.overflow = ovf;
    return r;
  endfunction

  // send one item, predicting its result as it is accepted
  task automatic send_operands(input logic [2:0] op, input logic [31:0] a_re,
                               input logic [31:0] a_im, input logic [31:0] b_re,
                               input logic [31:0] b_im);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b_im, b_re, a_im, a_re};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    results_due.push_back(complex_result(op, a_re, a_im, b_re, b_im));
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    if (results_due.size() != 0) begin
      s_axis_tvalid <= 1'b0;
      while (results_due.size() != 0) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      4: return $signed($urandom_range(0, 65535)) - 32768;
      5: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      default: return $urandom;
    endcase
  endfunction

  // extremes of every field and each special case of every operation
  task automatic test_directed();
    logic [31:0] corners[4];
    corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    for (int op = 0; op < 8; op++) begin
      send_operands(op[2:0], corners[op % 4], corners[(op + 1) % 4],
                    32'h0002_8000, 32'hfffe_0000);
    end
    send_operands(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
    send_operands(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_operands(OP_MUL, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
    // divide by zero, and divide by a tiny divisor that saturates
    send_operands(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
    send_operands(OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    send_operands(OP_DIV, 32'hfffe_0000, 32'h0003_0000, 32'h0001_0000, 32'hffff_0000);
    send_operands(OP_MAGSQ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_operands(OP_MAGSQ, 32'h0000_8000, 32'hffff_8000, 32'h0, 32'h0);
    send_operands(OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_operands(OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'hffff_ffff, 32'hffff_ffff);
    drain_results();
  endtask

  // random items in bursts with gaps between them
  task automatic test_random(input int count);
    int burst;
    int sent;
    logic [2:0] op;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && sent < count; i++) begin
        op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        send_operands(op, rand_part(), rand_part(),
                      ($urandom_range(0, 9) == 0) ? 32'h0 : rand_part(),
                      ($urandom_range(0, 9) == 0) ? 32'h0 : rand_part());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(0, 8));
      if (sent % 200 == 0) drain_results();
    end
  endtask

  // receiver stall pattern: phases of always ready, random and mostly stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode    <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (results_due.size() == 0) begin
        $error("result with no item outstanding: %h", got);
        failures++;
      end else begin
        want = results_due.pop_front();
        if (got.res_re !== want.res_re) begin
          $error("res_re expected %h actual %h", want.res_re, got.res_re);
          failures++;
        end
        if (got.res_im !== want.res_im) begin
          $error("res_im expected %h actual %h", want.res_im, got.res_im);
          failures++;
        end
        if (got.div_zero !== want.div_zero) begin
          $error("div_zero expected %b actual %b", want.div_zero, got.div_zero);
          failures++;
        end
        if (got.overflow !== want.overflow) begin
          $error("overflow expected %b actual %b", want.overflow, got.overflow);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    failures      = 0;
    cycle_count   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(750);
    drain_results();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (failures == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
